@@ design/assert_macros.svh @@
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

@@ design/ferc_pkg.sv @@
// Shared sizes, codes and the extent record for the free extent table.
package ferc_pkg;

   localparam int MAX_EXTENTS = 16;
   localparam int ADDR_BITS   = 16;
   localparam int IDX_BITS    = $clog2(MAX_EXTENTS);
   localparam int CNT_BITS    = $clog2(MAX_EXTENTS + 1);
   localparam int END_BITS    = ADDR_BITS + 1;
   localparam int SUM_BITS    = ADDR_BITS + 2;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_DUMP    = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef logic [ADDR_BITS-1:0] addr_type;

   typedef struct packed {
      addr_type base;
      addr_type length;
   } extent_type;

endpackage

@@ design/ferc_extent_ram.sv @@
// Extent table storage: one write port, one registered read port.
module ferc_extent_ram
   import ferc_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_BITS-1:0] wr_addr,
   input  extent_type          wr_data,
   input  logic                rd_en,
   input  logic [IDX_BITS-1:0] rd_addr,
   output extent_type          rd_data
);

   extent_type mem [MAX_EXTENTS];
   extent_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/free_extent_release_coalesce.sv @@
// Top level of the address-ordered free extent table with release coalescing.
//
// The block keeps up to MAX_EXTENTS free extents (base, length) sorted by
// address in a single-port-read, single-port-write table with a registered
// read port. A load (opcode 0) appends an extent at the end of the table,
// a release (opcode 1) scans from the lowest entry for the first extent at or
// above the end of the released block and merges it with the touching lower
// and/or upper neighbor or inserts it as a new extent, and a dump (opcode 2)
// returns every extent in address order with last set on the final one.
// Loads, releases and the unused opcode return one transaction with base and
// length zero and a status: ok, table full, address overflow, or list empty
// for a dump of an empty table. Overlap and ordering of loaded extents are
// not checked. One item is worked on at a time; req_stall is high from
// acceptance until the last result has entered the output register, which
// may still be holding it when the next request is accepted. A release reads
// the table through its one read port, first in a scan from the lowest entry
// and then, for an insert or a two-sided merge, in a shift of the entries
// above that point; a dump reads one extent at a time. No clearing pass is
// needed after reset.
`include "assert_macros.svh"

module free_extent_release_coalesce
   import ferc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_opcode,
   input  logic [ADDR_BITS-1:0] req_block_base,
   input  logic [ADDR_BITS-1:0] req_block_length,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ADDR_BITS-1:0] rsp_extent_base,
   output logic [ADDR_BITS-1:0] rsp_extent_length,
   output logic [1:0]           rsp_status,
   output logic                 rsp_last
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_DECIDE,
      S_SHIFT,
      S_EMIT,
      S_DUMP_RD,
      S_DUMP_WR
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           op_ff, op_in;
   addr_type             base_ff, base_in;
   addr_type             len_ff, len_in;
   logic [END_BITS-1:0]  end_ff, end_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [CNT_BITS-1:0]  issue_ff, issue_in;
   logic [CNT_BITS-1:0]  chk_ff, chk_in;
   logic                 pend_ff, pend_in;
   logic [CNT_BITS-1:0]  idx_ff, idx_in;
   extent_type           prev_ff, prev_in;
   extent_type           cur_ff, cur_in;
   logic [CNT_BITS-1:0]  src_ff, src_in;
   logic [CNT_BITS-1:0]  left_ff, left_in;
   logic                 dir_up_ff, dir_up_in;
   logic [IDX_BITS-1:0]  pdst_ff, pdst_in;
   logic [1:0]           status_ff, status_in;
   logic [CNT_BITS-1:0]  dump_ff, dump_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   addr_type             rsp_base_ff, rsp_base_in;
   addr_type             rsp_len_ff, rsp_len_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 ram_wr_en;
   logic [IDX_BITS-1:0]  ram_wr_addr;
   extent_type           ram_wr_data;
   logic                 ram_rd_en;
   logic [IDX_BITS-1:0]  ram_rd_addr;
   extent_type           ram_rd_data;

   logic                 out_free;
   logic                 rsp_load;
   logic                 addr_over;
   logic                 table_full;
   logic [END_BITS-1:0]  prev_end;
   logic                 low_touch;
   logic                 up_touch;
   addr_type             add_a;
   addr_type             add_b;
   logic [SUM_BITS-1:0]  merged;
   logic                 merge_over;
   logic [CNT_BITS-1:0]  idx_m1;
   logic [CNT_BITS-1:0]  dump_p1;

   ferc_extent_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Output register is free when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Block end lies above the address space unless it lands exactly on it.
   assign addr_over  = end_ff[ADDR_BITS] && (end_ff[ADDR_BITS-1:0] != '0);
   assign table_full = (count_ff >= CNT_BITS'(MAX_EXTENTS));

   // Neighbor tests against the extent below (prev) and the one found (cur).
   assign prev_end  = {1'b0, prev_ff.base} + {1'b0, prev_ff.length};
   assign low_touch = (idx_ff != '0) && (prev_end == {1'b0, base_ff});
   assign up_touch  = (idx_ff != count_ff) && ({1'b0, cur_ff.base} == end_ff);

   // One adder covers all three merge shapes.
   assign add_a      = low_touch ? prev_ff.length : '0;
   assign add_b      = up_touch ? cur_ff.length : '0;
   assign merged     = {2'b00, add_a} + {2'b00, len_ff} + {2'b00, add_b};
   assign merge_over = (merged[SUM_BITS-1:ADDR_BITS] != '0);

   assign idx_m1  = idx_ff - CNT_BITS'(1);
   assign dump_p1 = dump_ff + CNT_BITS'(1);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      base_in       = base_ff;
      len_in        = len_ff;
      end_in        = end_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      chk_in        = chk_ff;
      pend_in       = pend_ff;
      idx_in        = idx_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      src_in        = src_ff;
      left_in       = left_ff;
      dir_up_in     = dir_up_ff;
      pdst_in       = pdst_ff;
      status_in     = status_ff;
      dump_in       = dump_ff;
      rsp_base_in   = rsp_base_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_load      = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;

      case (state_ff)
         S_IDLE: begin
            // Capture the transaction and its end address.
            if (req_valid) begin
               op_in    = req_opcode;
               base_in  = req_block_base;
               len_in   = req_block_length;
               end_in   = {1'b0, req_block_base} + {1'b0, req_block_length};
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            status_in = ST_OK;
            state_in  = S_EMIT;
            case (op_ff)
               OP_LOAD: begin
                  if (len_ff == '0) begin
                     status_in = ST_OK;
                  end else if (addr_over) begin
                     status_in = ST_OVERFLOW;
                  end else if (table_full) begin
                     status_in = ST_FULL;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = count_ff[IDX_BITS-1:0];
                     ram_wr_data = '{base: base_ff, length: len_ff};
                     count_in    = count_ff + CNT_BITS'(1);
                  end
               end
               OP_RELEASE: begin
                  if (len_ff == '0) begin
                     status_in = ST_OK;
                  end else if (addr_over) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     issue_in = '0;
                     pend_in  = 1'b0;
                     state_in = S_SCAN;
                  end
               end
               OP_DUMP: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     dump_in  = '0;
                     state_in = S_DUMP_RD;
                  end
               end
               default: begin
                  status_in = ST_OK;
               end
            endcase
         end

         S_SCAN: begin
            // Stream reads one per cycle; stop at the first base at or above end.
            if (pend_ff && ({1'b0, ram_rd_data.base} >= end_ff)) begin
               idx_in   = chk_ff;
               cur_in   = ram_rd_data;
               pend_in  = 1'b0;
               state_in = S_DECIDE;
            end else if (!pend_ff && (issue_ff == count_ff)) begin
               idx_in   = count_ff;
               state_in = S_DECIDE;
            end else begin
               if (pend_ff) begin
                  prev_in = ram_rd_data;
               end
               if (issue_ff != count_ff) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = issue_ff[IDX_BITS-1:0];
                  pend_in     = 1'b1;
                  chk_in      = issue_ff;
                  issue_in    = issue_ff + CNT_BITS'(1);
               end else begin
                  pend_in = 1'b0;
               end
            end
         end

         S_DECIDE: begin
            status_in = ST_OK;
            state_in  = S_EMIT;
            pend_in   = 1'b0;
            if (low_touch || up_touch) begin
               if (merge_over) begin
                  status_in = ST_OVERFLOW;
               end else if (low_touch && up_touch) begin
                  // Grow the lower extent, then close the gap over the upper one.
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = idx_m1[IDX_BITS-1:0];
                  ram_wr_data = '{base: prev_ff.base, length: merged[ADDR_BITS-1:0]};
                  count_in    = count_ff - CNT_BITS'(1);
                  left_in     = count_ff - idx_ff - CNT_BITS'(1);
                  src_in      = idx_ff + CNT_BITS'(1);
                  dir_up_in   = 1'b0;
                  state_in    = S_SHIFT;
               end else if (low_touch) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = idx_m1[IDX_BITS-1:0];
                  ram_wr_data = '{base: prev_ff.base, length: merged[ADDR_BITS-1:0]};
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = idx_ff[IDX_BITS-1:0];
                  ram_wr_data = '{base: base_ff, length: merged[ADDR_BITS-1:0]};
               end
            end else if (table_full) begin
               status_in = ST_FULL;
            end else begin
               // Open a hole at the insert point, top entry first.
               count_in  = count_ff + CNT_BITS'(1);
               left_in   = count_ff - idx_ff;
               src_in    = count_ff - CNT_BITS'(1);
               dir_up_in = 1'b1;
               state_in  = S_SHIFT;
            end
         end

         S_SHIFT: begin
            // Write back the entry read last cycle to its new slot.
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pdst_ff;
               ram_wr_data = ram_rd_data;
            end
            if (left_ff != '0) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = src_ff[IDX_BITS-1:0];
               pend_in     = 1'b1;
               left_in     = left_ff - CNT_BITS'(1);
               if (dir_up_ff) begin
                  pdst_in = IDX_BITS'(src_ff + CNT_BITS'(1));
                  src_in  = src_ff - CNT_BITS'(1);
               end else begin
                  pdst_in = IDX_BITS'(src_ff - CNT_BITS'(1));
                  src_in  = src_ff + CNT_BITS'(1);
               end
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (dir_up_ff) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = idx_ff[IDX_BITS-1:0];
                     ram_wr_data = '{base: base_ff, length: len_ff};
                  end
                  state_in = S_EMIT;
               end
            end
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_base_in   = '0;
               rsp_len_in    = '0;
               rsp_status_in = status_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_DUMP_RD: begin
            // Read only once the output register can take the entry next cycle.
            if (out_free) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = dump_ff[IDX_BITS-1:0];
               state_in    = S_DUMP_WR;
            end
         end

         S_DUMP_WR: begin
            rsp_load      = 1'b1;
            rsp_base_in   = ram_rd_data.base;
            rsp_len_in    = ram_rd_data.length;
            rsp_status_in = ST_OK;
            rsp_last_in   = (dump_p1 == count_ff);
            dump_in       = dump_p1;
            state_in      = (dump_p1 == count_ff) ? S_IDLE : S_DUMP_RD;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      base_ff       <= base_in;
      len_ff        <= len_in;
      end_ff        <= end_in;
      issue_ff      <= issue_in;
      chk_ff        <= chk_in;
      idx_ff        <= idx_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      src_ff        <= src_in;
      left_ff       <= left_in;
      dir_up_ff     <= dir_up_in;
      pdst_ff       <= pdst_in;
      status_ff     <= status_in;
      dump_ff       <= dump_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_extent_base   = rsp_base_ff;
   assign rsp_extent_length = rsp_len_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

   // Table never holds more extents than it has rows.
   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_BITS'(MAX_EXTENTS))
   // A held result is never overwritten by the next one.
   `ASSERT_NEVER(a_no_overwrite, clock, reset, rsp_load && rsp_valid_ff && rsp_stall)
   // Shifts and scans never read the row being written in the same cycle.
   `ASSERT_NEVER(a_no_rw_clash, clock, reset, ram_wr_en && ram_rd_en && (ram_wr_addr == ram_rd_addr))
   // An accepted transaction always goes straight to decode.
   `ASSERT_ALWAYS(a_accept_exec, clock, reset, (req_valid && !req_stall) |=> (state_ff == S_EXEC))

endmodule

@@ tb/free_extent_release_coalesce_test.sv @@
// Self-checking testbench for the free extent table: loads, coalescing releases and dumps.
module free_extent_release_coalesce_test
   import ferc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // The package names only the three live opcodes; the fourth is a no-op.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Address arithmetic is done two bits wider than the block so that an
   // end of exactly 2^ADDR_BITS and a merged length past it stay visible.
   localparam logic [17:0] ADDR_LIMIT = 18'h10000;
   localparam logic [17:0] LEN_MAX    = 18'h0FFFF;

   localparam int IDLE_PERCENT = 17;
   // Drain for longer than the longest release takes.
   localparam int DRAIN_CYCLES = 60;
   // Slowest run: up to 311 items, each up to 16 results behind receiver stalls,
   // plus sender gaps and release walks. Allow several times that.
   localparam int LIMIT_CYCLES = 500000;

   typedef struct {
      addr_type   base;
      addr_type   length;
      logic [1:0] status;
      logic       last;
   } extent_report_type;

   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_opcode       = OP_LOAD;
   logic [ADDR_BITS-1:0] req_block_base   = '0;
   logic [ADDR_BITS-1:0] req_block_length = '0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic [ADDR_BITS-1:0] rsp_extent_base;
   logic [ADDR_BITS-1:0] rsp_extent_length;
   logic [1:0]           rsp_status;
   logic                 rsp_last;

   // Predicted free list, kept in step with every accepted request.
   addr_type free_base[MAX_EXTENTS];
   addr_type free_length[MAX_EXTENTS];
   int       free_count = 0;

   // Reports the block still owes, oldest first.
   extent_report_type expected_reports[$];

   int failures    = 0;
   int cycle_count = 0;
   bit idle_enable = 1'b1;

   free_extent_release_coalesce dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_block_base    (req_block_base),
      .req_block_length  (req_block_length),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_extent_base   (rsp_extent_base),
      .rsp_extent_length (rsp_extent_length),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run if the block hangs or a transaction never comes.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("free_extent_release_coalesce regression: fail");
         $finish;
      end
   end

   // Receiver back-pressure: stall at random while idling is enabled.
   always @(posedge clock) begin
      rsp_stall <= idle_enable && ($urandom_range(99) < IDLE_PERCENT);
   end

   // ---------------------------------------------------------------------
   // Free list prediction
   // ---------------------------------------------------------------------

   // One past the last address of a predicted extent.
   function automatic logic [17:0] extent_end(int idx);
      return {2'b00, free_base[idx]} + {2'b00, free_length[idx]};
   endfunction

   // Append an extent as given; order and overlap are not checked.
   function automatic logic [1:0] predict_load(addr_type base, addr_type length);
      logic [17:0] stop;
      stop = {2'b00, base} + {2'b00, length};
      if (length == '0) return ST_OK;
      if (stop > ADDR_LIMIT) return ST_OVERFLOW;
      if (free_count >= MAX_EXTENTS) return ST_FULL;
      free_base[free_count]   = base;
      free_length[free_count] = length;
      free_count++;
      return ST_OK;
   endfunction

   // Coalesce a released block with its touching neighbors, or insert it.
   function automatic logic [1:0] predict_release(addr_type base, addr_type length);
      logic [17:0] stop;
      logic [17:0] merged;
      int          slot;
      bit          low_touch;
      bit          up_touch;
      stop = {2'b00, base} + {2'b00, length};
      if (length == '0) return ST_OK;
      if (stop > ADDR_LIMIT) return ST_OVERFLOW;
      // Search always starts at the lowest extent.
      slot = 0;
      while (slot < free_count && {2'b00, free_base[slot]} < stop) slot++;
      low_touch = 1'b0;
      up_touch  = 1'b0;
      if (slot > 0) low_touch = (extent_end(slot - 1) == {2'b00, base});
      if (slot < free_count) up_touch = ({2'b00, free_base[slot]} == stop);

      if (low_touch && up_touch) begin
         merged = {2'b00, free_length[slot-1]} + {2'b00, length}
                  + {2'b00, free_length[slot]};
         if (merged > LEN_MAX) return ST_OVERFLOW;
         free_length[slot-1] = merged[15:0];
         for (int j = slot; j + 1 < free_count; j++) begin
            free_base[j]   = free_base[j+1];
            free_length[j] = free_length[j+1];
         end
         free_count--;
      end else if (low_touch) begin
         merged = {2'b00, free_length[slot-1]} + {2'b00, length};
         if (merged > LEN_MAX) return ST_OVERFLOW;
         free_length[slot-1] = merged[15:0];
      end else if (up_touch) begin
         merged = {2'b00, free_length[slot]} + {2'b00, length};
         if (merged > LEN_MAX) return ST_OVERFLOW;
         free_base[slot]   = base;
         free_length[slot] = merged[15:0];
      end else begin
         if (free_count >= MAX_EXTENTS) return ST_FULL;
         for (int j = free_count; j > slot; j--) begin
            free_base[j]   = free_base[j-1];
            free_length[j] = free_length[j-1];
         end
         free_base[slot]   = base;
         free_length[slot] = length;
         free_count++;
      end
      return ST_OK;
   endfunction

   // Queue the reports that one accepted request will cause.
   function automatic void predict_reports(logic [1:0] op, addr_type base,
                                           addr_type length);
      extent_report_type rep;
      rep.base   = '0;
      rep.length = '0;
      rep.status = ST_OK;
      rep.last   = 1'b1;
      case (op)
         OP_LOAD: begin
            rep.status = predict_load(base, length);
            expected_reports.push_back(rep);
         end
         OP_RELEASE: begin
            rep.status = predict_release(base, length);
            expected_reports.push_back(rep);
         end
         OP_DUMP: begin
            if (free_count == 0) begin
               rep.status = ST_EMPTY;
               expected_reports.push_back(rep);
            end else begin
               for (int k = 0; k < free_count; k++) begin
                  rep.base   = free_base[k];
                  rep.length = free_length[k];
                  rep.last   = (k + 1 == free_count);
                  expected_reports.push_back(rep);
               end
            end
         end
         default: begin
            expected_reports.push_back(rep);
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   function automatic void check_field(string field, int unsigned want,
                                       int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         failures++;
      end
   endfunction

   // Sample at the falling edge: everything driven at the rising edge has
   // settled, and a transaction seen here is taken at the next rising edge.
   always @(negedge clock) begin : check_reports
      extent_report_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $error("unexpected result transaction: base 0x%0h length 0x%0h status %0d",
                   rsp_extent_base, rsp_extent_length, rsp_status);
            failures++;
         end else begin
            want = expected_reports.pop_front();
            check_field("extent_base", want.base, rsp_extent_base);
            check_field("extent_length", want.length, rsp_extent_length);
            check_field("status", want.status, rsp_status);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request driving
   // ---------------------------------------------------------------------

   // Drive one request transaction and hold it until the block takes it.
   // Called and returning just after a rising edge, so valid gets a single
   // update per edge even when requests follow back to back.
   task automatic send_request(logic [1:0] op, addr_type base, addr_type length);
      bit accepted;
      // Insert a random gap with valid low.
      while (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_block_base   <= base;
      req_block_length <= length;
      do begin
         @(negedge clock);
         accepted = !req_stall;
         @(posedge clock);
      end while (!accepted);
      predict_reports(op, base, length);
   endtask

   // Base on a coarse grid so that the block rarely touches a neighbor.
   function automatic addr_type isolated_base();
      return addr_type'($urandom_range(1023)) * 16'd64 + 16'd8;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Dump of an empty list, and the unused opcode with every field set and clear.
   task automatic test_empty_and_unused();
      send_request(OP_DUMP, 16'hFFFF, 16'hFFFF);
      send_request(OP_UNUSED, 16'hFFFF, 16'hFFFF);
      send_request(OP_UNUSED, 16'h0000, 16'h0000);
   endtask

   // Zero lengths change nothing; an end past the address space is rejected.
   task automatic test_zero_and_overflow();
      send_request(OP_LOAD, 16'h1234, 16'h0000);
      send_request(OP_LOAD, 16'hFFFF, 16'hFFFF);
      send_request(OP_RELEASE, 16'h0000, 16'h0000);
      send_request(OP_RELEASE, 16'hFFF0, 16'h0011);
   endtask

   // Merge below, above, both sides and neither; merges that overflow.
   task automatic test_coalescing();
      send_request(OP_LOAD, 16'h0100, 16'h0100);
      send_request(OP_LOAD, 16'h0400, 16'h0100);
      send_request(OP_RELEASE, 16'h0200, 16'h0080);   // grows the lower extent
      send_request(OP_RELEASE, 16'h0380, 16'h0080);   // grows the upper extent
      send_request(OP_RELEASE, 16'h0280, 16'h0100);   // bridges the two
      send_request(OP_RELEASE, 16'h0000, 16'h0100);   // extends down to zero
      send_request(OP_RELEASE, 16'h0500, 16'hFB00);   // lower merge too long
      send_request(OP_RELEASE, 16'hFFF0, 16'h0010);   // new extent at the top
      send_request(OP_RELEASE, 16'h0800, 16'h0010);   // new extent in between
      send_request(OP_DUMP, 16'h0000, 16'h0000);
      send_request(OP_RELEASE, 16'h0000, 16'hFFF0);   // upper merge too long
   endtask

   // Fill the table, hit the full status from a load and from an insert,
   // then dump the largest list.
   task automatic test_table_full();
      int tries;
      tries = 0;
      while (free_count < MAX_EXTENTS && tries < 60) begin
         send_request(OP_RELEASE, isolated_base(), addr_type'($urandom_range(1, 32)));
         tries++;
      end
      send_request(OP_LOAD, 16'h0004, 16'h0001);
      send_request(OP_RELEASE, isolated_base(), 16'h0001);
      send_request(OP_DUMP, 16'h0000, 16'h0000);
   endtask

   // Mostly well-formed releases aimed at the predicted list, plus loads,
   // dumps, zero lengths and fully random noise.
   task automatic test_random_traffic(int count);
      int unsigned pick;
      int unsigned k;
      logic [17:0] stop;
      logic [1:0]  op;
      addr_type    b;
      addr_type    l;
      repeat (count) begin
         pick = $urandom_range(99);
         op   = OP_RELEASE;
         b    = addr_type'($urandom);
         l    = addr_type'($urandom_range(1, 16'h0100));
         if (pick < 25 && free_count > 1) begin
            // Fill the hole between two neighbors.
            k    = $urandom_range(free_count - 2);
            stop = extent_end(k);
            if ({2'b00, free_base[k+1]} > stop) begin
               b = stop[15:0];
               l = free_base[k+1] - stop[15:0];
            end
         end else if (pick < 37 && free_count > 0) begin
            // Touch an extent from above.
            k    = $urandom_range(free_count - 1);
            stop = extent_end(k);
            if (stop < ADDR_LIMIT) b = stop[15:0];
         end else if (pick < 49 && free_count > 0) begin
            // Touch an extent from below.
            k = $urandom_range(free_count - 1);
            if (free_base[k] != '0) begin
               if (l > free_base[k]) l = free_base[k];
               b = free_base[k] - l;
            end
         end else if (pick < 64) begin
            b = isolated_base();
            l = addr_type'($urandom_range(1, 32));
         end else if (pick < 70) begin
            // Append above the highest extent when it fits.
            op = OP_LOAD;
            if (free_count > 0) begin
               stop = extent_end(free_count - 1) + 18'($urandom_range(1, 64));
               if (stop + {2'b00, l} <= ADDR_LIMIT) b = stop[15:0];
            end
         end else if (pick < 80) begin
            op = OP_DUMP;
         end else if (pick < 85) begin
            op = 2'($urandom);
            l  = '0;
         end else begin
            op = 2'($urandom);
            l  = addr_type'($urandom);
         end
         send_request(op, b, l);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_and_unused();
      test_zero_and_overflow();
      test_coalescing();
      test_table_full();
      test_random_traffic(100);
      // Run a stretch with both sides at full rate.
      idle_enable = 1'b0;
      test_random_traffic(50);
      idle_enable = 1'b1;
      test_random_traffic(80);

      // Drop valid and let the block return everything it owes.
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("free_extent_release_coalesce regression: pass");
      end else begin
         $display("free_extent_release_coalesce regression: fail");
      end
      $finish;
   end

endmodule
